// ===== design/ptm_pkg.sv =====
// Shared types and constants for the page table map/unmap/lookup block.
// Used by the walker and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

	// Table pool
	localparam int TABLE_COUNT = 16;
	localparam int IDX_W       = 9;
	localparam int ENTRIES     = 512;
	localparam int TBL_W       = $clog2(TABLE_COUNT);
	localparam int NFT_W       = $clog2(TABLE_COUNT + 1);
	localparam int MEM_DEPTH   = TABLE_COUNT * ENTRIES;
	localparam int MEM_AW      = TBL_W + IDX_W;

	// Entry bits
	localparam int E_PRESENT = 0;
	localparam int E_WRITE   = 1;
	localparam int E_USER    = 2;
	localparam int E_HUGE    = 7;

	localparam logic [63:0] ADDR_MASK      = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] HUGE_ADDR_MASK = 64'h000F_FFFF_FFE0_0000;
	localparam logic [63:0] LEAF_KEEP_MASK = ~ADDR_MASK & ~(64'h1 << E_HUGE);

	typedef enum logic [1:0] {
		CMD_MAP4K  = 2'd0,
		CMD_MAP2M  = 2'd1,
		CMD_UNMAP  = 2'd2,
		CMD_LOOKUP = 2'd3
	} ptm_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_NOT_MAPPED = 2'd1,
		ST_NO_TABLE   = 2'd2,
		ST_HUGE_BLOCK = 2'd3
	} ptm_status_t;

	typedef struct packed {
		ptm_cmd_t     cmd;
		logic [47:0]  virt_addr;
		logic [51:0]  target_phys;
		logic [63:0]  entry_flags;
	} cmd_word_t;

	typedef struct packed {
		logic [51:0]  translated_phys;
		ptm_status_t  status;
	} rsp_word_t;

	// One access to the table store per cycle
	typedef struct packed {
		logic              en;
		logic              we;
		logic [MEM_AW-1:0] addr;
		logic [63:0]       wdata;
	} ptm_mem_req_t;

endpackage

`default_nettype wire

// ===== design/page_table_map_unmap_lookup.sv =====
// Top level of the four-level page table block: walker, table store RAM
// and response register. Depends on ptm_pkg, ptm_walk and ptm_ram.
//
// Four-level x86-64 page table held on chip: TABLE_COUNT tables of 512
// 64-bit entries in one single-port RAM, table 0 the root. Each command word
// (map 4 KiB, map 2 MiB, unmap, lookup) walks virt_addr bits 47:12 and
// returns one response word with a status and, for a lookup that hits, the
// physical address. Intermediate entries store table numbers, not physical
// addresses; missing tables come from a bump allocator and are never freed.
// After reset the block sweeps the RAM to zero, one entry a cycle, over all
// TABLE_COUNT*512 entries (8192 at 16 tables); cmd_ready stays low until the
// sweep ends. The block takes one command at a time; each level issues a RAM
// read and then evaluates the entry, with any write-back, and a 4 KiB map
// writes its leaf in place of the last read; a refused or missing entry ends
// the walk early. The response sits in an output register, so the next
// command can be taken while the last response waits.
`timescale 1ns / 1ps
`default_nettype none

module page_table_map_unmap_lookup import ptm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire cmd_word_t cmd_word,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp_word
);

	ptm_mem_req_t  mem_req;
	logic [63:0]   mem_rdata;
	logic          res_valid;
	logic          res_ready;
	rsp_word_t     res_word;
	logic          rsp_valid_q;
	rsp_word_t     rsp_word_q;

	ptm_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// table store
	ptm_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (64)
	) u_ram (
		.clk   (clk),
		.en    (mem_req.en),
		.we    (mem_req.we),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	// response register: free when empty or being drained this cycle
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_word_q <= res_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// walker goes busy the cycle after it takes a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("walker still ready after accepting a word");

	// no table store write while waiting for a command
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !mem_req.we)
		else $error("table store written while idle");

	// a handed-off response shows up on the port next cycle
	a_rsp_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> rsp_valid && (rsp_word == $past(res_word)))
		else $error("response word lost in output register");

	// failed commands never carry an address
	a_phys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.status != ST_DONE) |-> rsp_word.translated_phys == '0)
		else $error("address returned with failing status");

endmodule

`default_nettype wire

// ===== design/ptm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] ram_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				ram_q[addr] <= wdata;
			end else begin
				rd_q <= ram_q[addr];
			end
		end
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

// ===== design/ptm_walk.sv =====
// Walk sequencer: clears the table store, then runs one command at a time
// through read / evaluate / write-back steps. Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptm_walk import ptm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_ready,
	input  wire cmd_word_t    cmd_word,
	output logic              res_valid,
	input  wire logic         res_ready,
	output rsp_word_t         res_word,
	output ptm_mem_req_t      mem_req,
	input  wire logic [63:0]  mem_rdata
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_EVAL,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		LVL_PML4,
		LVL_PDPT,
		LVL_PD,
		LVL_PT
	} lvl_t;

	state_t             state_q;
	lvl_t               lvl_q;
	logic [TBL_W-1:0]   tbl_q;
	logic [NFT_W-1:0]   nft_q;
	logic [MEM_AW-1:0]  clr_q;
	cmd_word_t          cw_q;
	logic [51:0]        phys_q;
	ptm_status_t        st_q;

	logic [IDX_W-1:0]   idx;
	logic [63:0]        leaf_flags;
	logic [63:0]        leaf_entry;
	logic [63:0]        huge_entry;
	logic [63:0]        alloc_entry;
	logic               is_make;
	logic               leaf_wr;

	// evaluate-step decisions
	logic               e_present;
	logic               e_huge;
	logic               child_ok;
	logic [TBL_W-1:0]   child_n;
	logic               go_down;
	logic               alloc;
	logic               fin;
	ptm_status_t        fin_st;
	logic [51:0]        fin_phys;
	logic               ev_wr;
	logic [63:0]        ev_wdata;
	logic [TBL_W-1:0]   down_tbl;

	always_comb begin
		case (lvl_q)
			LVL_PML4: idx = cw_q.virt_addr[47:39];
			LVL_PDPT: idx = cw_q.virt_addr[38:30];
			LVL_PD:   idx = cw_q.virt_addr[29:21];
			default:  idx = cw_q.virt_addr[20:12];
		endcase
	end

	assign is_make     = (cw_q.cmd == CMD_MAP4K) || (cw_q.cmd == CMD_MAP2M);
	assign leaf_flags  = cw_q.entry_flags & LEAF_KEEP_MASK;
	assign leaf_entry  = (64'(cw_q.target_phys) & ADDR_MASK) | leaf_flags
	                   | (64'h1 << E_PRESENT);
	assign huge_entry  = (64'(cw_q.target_phys) & HUGE_ADDR_MASK) | leaf_flags
	                   | (64'h1 << E_PRESENT) | (64'h1 << E_HUGE);
	assign alloc_entry = ((64'(nft_q) << 12) & ADDR_MASK) | (64'h1 << E_PRESENT)
	                   | (64'h1 << E_WRITE)
	                   | (cw_q.entry_flags & (64'h1 << E_USER));
	assign leaf_wr     = (lvl_q == LVL_PT) && (cw_q.cmd == CMD_MAP4K);

	assign e_present = mem_rdata[E_PRESENT];
	assign e_huge    = mem_rdata[E_HUGE];
	assign child_n   = mem_rdata[12 +: TBL_W];
	assign child_ok  = (mem_rdata[51:12] != 40'd0)
	                 && (mem_rdata[51:12] < 40'(TABLE_COUNT));

	always_comb begin
		go_down  = 1'b0;
		alloc    = 1'b0;
		fin      = 1'b0;
		fin_st   = ST_DONE;
		fin_phys = '0;
		ev_wr    = 1'b0;
		ev_wdata = '0;
		if ((lvl_q == LVL_PML4) || (lvl_q == LVL_PDPT)
		    || ((lvl_q == LVL_PD) && (cw_q.cmd == CMD_MAP4K) && !e_huge)) begin
			if (e_present) begin
				if (child_ok) begin
					go_down = 1'b1;
				end else begin
					fin    = 1'b1;
					fin_st = ST_NOT_MAPPED;
				end
			end else if (!is_make) begin
				fin    = 1'b1;
				fin_st = ST_NOT_MAPPED;
			end else if (nft_q >= NFT_W'(TABLE_COUNT)) begin
				fin    = 1'b1;
				fin_st = ST_NO_TABLE;
			end else begin
				alloc    = 1'b1;
				go_down  = 1'b1;
				ev_wr    = 1'b1;
				ev_wdata = alloc_entry;
			end
		end else if ((lvl_q == LVL_PD) && (cw_q.cmd == CMD_MAP2M)) begin
			ev_wr    = 1'b1;
			ev_wdata = huge_entry;
			fin      = 1'b1;
		end else if ((lvl_q == LVL_PD) && (cw_q.cmd == CMD_MAP4K)) begin
			fin    = 1'b1;
			fin_st = ST_HUGE_BLOCK;
		end else if (!e_present) begin
			fin    = 1'b1;
			fin_st = ST_NOT_MAPPED;
		end else if ((lvl_q == LVL_PD) && e_huge) begin
			fin = 1'b1;
			if (cw_q.cmd == CMD_UNMAP) begin
				ev_wr = 1'b1;
			end else begin
				fin_phys = {mem_rdata[51:21], cw_q.virt_addr[20:0]};
			end
		end else if (lvl_q == LVL_PD) begin
			if (child_ok) begin
				go_down = 1'b1;
			end else begin
				fin    = 1'b1;
				fin_st = ST_NOT_MAPPED;
			end
		end else begin
			fin = 1'b1;
			if (cw_q.cmd == CMD_UNMAP) begin
				ev_wr = 1'b1;
			end else begin
				fin_phys = {mem_rdata[51:12], cw_q.virt_addr[11:0]};
			end
		end
	end

	assign down_tbl = alloc ? nft_q[TBL_W-1:0] : child_n;

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_CLEAR: begin
				mem_req.en   = 1'b1;
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
			end
			S_ISSUE: begin
				mem_req.en    = 1'b1;
				mem_req.we    = leaf_wr;
				mem_req.addr  = {tbl_q, idx};
				mem_req.wdata = leaf_entry;
			end
			S_EVAL: begin
				mem_req.en    = ev_wr;
				mem_req.we    = ev_wr;
				mem_req.addr  = {tbl_q, idx};
				mem_req.wdata = ev_wdata;
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lvl_q   <= LVL_PML4;
			tbl_q   <= '0;
			nft_q   <= NFT_W'(1);
			clr_q   <= '0;
			st_q    <= ST_DONE;
			phys_q  <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cw_q    <= cmd_word;
						lvl_q   <= LVL_PML4;
						tbl_q   <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (leaf_wr) begin
						st_q    <= ST_DONE;
						phys_q  <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (alloc) begin
						nft_q <= nft_q + NFT_W'(1);
					end
					if (go_down) begin
						tbl_q   <= down_tbl;
						lvl_q   <= lvl_t'(lvl_q + 2'd1);
						state_q <= S_ISSUE;
					end else begin
						st_q    <= fin_st;
						phys_q  <= fin_phys;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_ready               = (state_q == S_IDLE);
	assign res_valid               = (state_q == S_DONE);
	assign res_word.translated_phys = phys_q;
	assign res_word.status          = st_q;

endmodule

`default_nettype wire

// ===== sim/ptm_checker.sv =====
// Checker for the page table block: watches both word channels, predicts each
// response from its own shadow of the table store, and compares. Depends on ptm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptm_checker import ptm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire logic      cmd_ready,
	input  wire cmd_word_t cmd_word,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_ready,
	input  wire rsp_word_t rsp_word,
	output int             errors,
	output int             outstanding,
	output int             checked,
	output int             lookup_hits,
	output int             pool_empty,
	output int             huge_blocked
);

	localparam logic [63:0] HUGE_OFF_MASK = 64'h1F_FFFF;
	localparam logic [63:0] PAGE_OFF_MASK = 64'hFFF;
	localparam logic [63:0] BIT_PRESENT   = 64'h1 << E_PRESENT;
	localparam logic [63:0] BIT_WRITE     = 64'h1 << E_WRITE;
	localparam logic [63:0] BIT_USER      = 64'h1 << E_USER;
	localparam logic [63:0] BIT_HUGE      = 64'h1 << E_HUGE;

	logic [63:0] shadow_mem [MEM_DEPTH];
	int unsigned tables_used;	// next table number the allocator hands out
	rsp_word_t   rsp_due [$];
	rsp_word_t   want;
	int          bad;

	function automatic int unsigned slot_index(int unsigned tbl, logic [47:0] va, int shift);
		return tbl * ENTRIES + 32'((va >> shift) & 48'h1FF);
	endfunction

	// Follow the entry at one level, or create it when grow is set.
	function automatic ptm_status_t step_level(int unsigned tbl, logic [47:0] va, int shift,
			logic [63:0] flags, bit grow, output int unsigned child);
		int unsigned slot;
		logic [63:0] ent;
		logic [39:0] num;
		slot = slot_index(tbl, va, shift);
		ent = shadow_mem[slot];
		child = 0;
		if (ent[E_PRESENT]) begin
			num = ent[51:12];
			if (num == 0 || num >= TABLE_COUNT)
				return ST_NOT_MAPPED;
			child = 32'(num);
			return ST_DONE;
		end
		if (!grow)
			return ST_NOT_MAPPED;
		if (tables_used >= TABLE_COUNT)
			return ST_NO_TABLE;
		child = tables_used;
		tables_used++;
		shadow_mem[slot] = ((64'(child) << 12) & ADDR_MASK) | BIT_PRESENT | BIT_WRITE
			| (flags & BIT_USER);
		return ST_DONE;
	endfunction

	function automatic rsp_word_t apply_command(cmd_word_t w);
		logic [63:0] va, leaf, ent, phys;
		int unsigned t1, t2, t3, pd_slot, pt_slot;
		ptm_status_t st;
		rsp_word_t r;
		bit grow;
		va = {16'h0, w.virt_addr};
		leaf = (w.entry_flags & LEAF_KEEP_MASK) | BIT_PRESENT;
		phys = '0;
		t1 = 0;
		t2 = 0;
		t3 = 0;
		grow = (w.cmd == CMD_MAP4K) || (w.cmd == CMD_MAP2M);
		st = step_level(0, w.virt_addr, 39, w.entry_flags, grow, t1);
		if (st == ST_DONE)
			st = step_level(t1, w.virt_addr, 30, w.entry_flags, grow, t2);
		if (st == ST_DONE) begin
			pd_slot = slot_index(t2, w.virt_addr, 21);
			ent = shadow_mem[pd_slot];
			case (w.cmd)
				CMD_MAP2M: begin
					// overwrites whatever sat there, page table pointer included
					shadow_mem[pd_slot] = ({12'h0, w.target_phys} & HUGE_ADDR_MASK) | leaf
						| BIT_HUGE;
				end
				CMD_MAP4K: begin
					if (ent[E_HUGE]) begin
						st = ST_HUGE_BLOCK;
					end else begin
						st = step_level(t2, w.virt_addr, 21, w.entry_flags, 1'b1, t3);
						if (st == ST_DONE)
							shadow_mem[slot_index(t3, w.virt_addr, 12)] =
								({12'h0, w.target_phys} & ADDR_MASK) | leaf;
					end
				end
				default: begin
					if (!ent[E_PRESENT]) begin
						st = ST_NOT_MAPPED;
					end else if (ent[E_HUGE]) begin
						if (w.cmd == CMD_UNMAP)
							shadow_mem[pd_slot] = '0;
						else
							phys = (ent & HUGE_ADDR_MASK) | (va & HUGE_OFF_MASK);
					end else begin
						st = step_level(t2, w.virt_addr, 21, w.entry_flags, 1'b0, t3);
						if (st == ST_DONE) begin
							pt_slot = slot_index(t3, w.virt_addr, 12);
							ent = shadow_mem[pt_slot];
							if (!ent[E_PRESENT])
								st = ST_NOT_MAPPED;
							else if (w.cmd == CMD_UNMAP)
								shadow_mem[pt_slot] = '0;
							else
								phys = (ent & ADDR_MASK) | (va & PAGE_OFF_MASK);
						end
					end
				end
			endcase
		end
		r.status = st;
		r.translated_phys = (st == ST_DONE) ? phys[51:0] : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_mem[i])
				shadow_mem[i] = '0;
			tables_used = 1;
			rsp_due.delete();
			errors <= 0;
			outstanding <= 0;
			checked <= 0;
			lookup_hits <= 0;
			pool_empty <= 0;
			huge_blocked <= 0;
		end else begin
			bad = 0;
			if (cmd_valid && cmd_ready) begin
				want = apply_command(cmd_word);
				rsp_due.push_back(want);
				lookup_hits <= lookup_hits
					+ int'(cmd_word.cmd == CMD_LOOKUP && want.status == ST_DONE);
				pool_empty <= pool_empty + int'(want.status == ST_NO_TABLE);
				huge_blocked <= huge_blocked + int'(want.status == ST_HUGE_BLOCK);
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					$error("response word with none expected: translated_phys %h status %0d",
						rsp_word.translated_phys, rsp_word.status);
					bad++;
				end else begin
					want = rsp_due.pop_front();
					if (rsp_word.translated_phys !== want.translated_phys) begin
						$error("translated_phys: expected %h, got %h",
							want.translated_phys, rsp_word.translated_phys);
						bad++;
					end
					if (rsp_word.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_word.status);
						bad++;
					end
					checked <= checked + 1;
				end
			end
			errors <= errors + bad;
			outstanding <= rsp_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Top of the page table block testbench: clock, reset, command stimulus,
// response back-pressure and verdict. Depends on ptm_pkg, the block and ptm_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import ptm_pkg::*;

	// The post-reset RAM sweep keeps cmd_ready low while it clears all TABLE_COUNT*512
	// entries, so the no-progress limit has to sit well above the sweep.
	localparam int IDLE_LIMIT    = 40000;
	localparam int HOLD_CYCLES   = 300;	// long receiver stall to back the block up
	localparam int SETTLE_CYCLES = 24;	// settling wait after the final drain, before the summary

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	cmd_word_t cmd_word = '0;
	logic      rsp_ready = 1'b0;
	logic      cmd_ready;
	logic      rsp_valid;
	rsp_word_t rsp_word;

	int snd_idle_pct = 12;
	int rcv_idle_pct = 64;
	int hold_seq = 0;	// bumped by stimulus to request a receiver hold-off
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// Recently mapped addresses; reused so lookups and unmaps actually hit.
	logic [47:0] mapped_va [$];

	int errors, outstanding, checked, lookup_hits, pool_empty, huge_blocked;

	page_table_map_unmap_lookup DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	ptm_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_word     (cmd_word),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_word     (rsp_word),
		.errors       (errors),
		.outstanding  (outstanding),
		.checked      (checked),
		.lookup_hits  (lookup_hits),
		.pool_empty   (pool_empty),
		.huge_blocked (huge_blocked)
	);

	always #1 clk = ~clk;

	// Response side: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic cmd_word_t mk_word(ptm_cmd_t op, logic [47:0] va, logic [51:0] pa,
			logic [63:0] fl);
		cmd_word_t w;
		w.cmd = op;
		w.virt_addr = va;
		w.target_phys = pa;
		w.entry_flags = fl;
		return w;
	endfunction

	// Small set of table indices per level so walks share tables; the pool is
	// only 15 tables deep and would drain at once on fully random addresses.
	function automatic logic [8:0] hot_idx(int choices);
		case ($urandom_range(choices - 1))
			0: return 9'h000;
			1: return 9'h1FF;
			2: return 9'h0A5;
			default: return 9'h133;
		endcase
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int r, c;
		logic [63:0] bits;
		logic [47:0] base;
		r = $urandom_range(99);
		c = $urandom_range(99);
		bits = {$urandom, $urandom};
		w.target_phys = bits[51:0];
		w.entry_flags = {$urandom, $urandom};
		if (mapped_va.size() != 0 && r < 35) begin
			// revisit a mapped page at a random offset
			base = mapped_va[$urandom_range(mapped_va.size() - 1)];
			w.virt_addr = {base[47:12], 12'($urandom)};
			w.cmd = c < 60 ? CMD_LOOKUP : c < 80 ? CMD_UNMAP : c < 90 ? CMD_MAP4K : CMD_MAP2M;
		end else if (r < 90) begin
			w.virt_addr = {hot_idx(2), hot_idx(3), hot_idx(4), 9'($urandom), 12'($urandom)};
			w.cmd = c < 35 ? CMD_MAP4K : c < 45 ? CMD_MAP2M : c < 60 ? CMD_UNMAP : CMD_LOOKUP;
		end else begin
			// scattered addresses, mostly unmaps and lookups so they do not eat the pool
			bits = {$urandom, $urandom};
			w.virt_addr = bits[47:0];
			w.cmd = c < 15 ? CMD_MAP4K : c < 25 ? CMD_MAP2M : c < 60 ? CMD_UNMAP : CMD_LOOKUP;
		end
		if (w.cmd == CMD_MAP4K || w.cmd == CMD_MAP2M) begin
			mapped_va.push_back(w.virt_addr);
			if (mapped_va.size() > 64)
				void'(mapped_va.pop_front());
		end
		return w;
	endfunction

	// Offer one command word; returns at the edge that accepts it, with valid
	// still high so a following word can go out back to back.
	task automatic send_word(cmd_word_t w);
		int gap;
		if ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// Stop offering and wait for every expected response word.
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic run_random(int count, int hold_at);
		int n;
		for (n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_seq <= hold_seq + 1;
			send_word(random_word());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table misses, extreme fields, huge pages, remaps, unmaps.
		send_word(mk_word(CMD_LOOKUP, 48'h0, '0, '0));
		send_word(mk_word(CMD_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0));
		// all-ones flags: address and huge bits must be dropped, user copied up
		send_word(mk_word(CMD_MAP4K, 48'h0, 52'hF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
		send_word(mk_word(CMD_LOOKUP, 48'hFFF, '0, '0));
		send_word(mk_word(CMD_MAP4K, 48'hFFFF_FFFF_FFFF, '0, '0));
		send_word(mk_word(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));
		send_word(mk_word(CMD_MAP2M, 48'h20_0000, 52'hF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555));
		send_word(mk_word(CMD_LOOKUP, 48'h3F_FFFF, '0, '0));
		// 4 KiB map under a huge entry is refused
		send_word(mk_word(CMD_MAP4K, 48'h20_1000, 52'h1_0000, 64'h3));
		// huge map over a PD entry that points at a page table
		send_word(mk_word(CMD_MAP2M, 48'h0, 52'hA_BCDE_F012_3456, '0));
		send_word(mk_word(CMD_LOOKUP, 48'h1234, '0, '0));
		// remap of an existing leaf
		send_word(mk_word(CMD_MAP4K, 48'hFFFF_FFFF_FFFF, 52'h1_2345_6789_A000,
			64'hAAAA_AAAA_AAAA_AAAA));
		send_word(mk_word(CMD_LOOKUP, 48'hFFFF_FFFF_F000, '0, '0));
		send_word(mk_word(CMD_UNMAP, 48'h20_0000, '0, '0));
		send_word(mk_word(CMD_LOOKUP, 48'h20_0000, '0, '0));
		send_word(mk_word(CMD_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0));
		send_word(mk_word(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));
		send_word(mk_word(CMD_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0));
		send_word(mk_word(CMD_MAP2M, 48'hFFFF_FFE0_0000, 52'h7_0000_0020_0000,
			64'h8000_0000_0000_0004));
		send_word(mk_word(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));
		// misses partway down: PDPT entry missing, then PD entry missing
		send_word(mk_word(CMD_LOOKUP, 48'h0000_4000_0000, '0, '0));
		send_word(mk_word(CMD_UNMAP, 48'h0000_0040_0000, '0, '0));

		// Phase 1: light sender gaps, heavy receiver stalls, one long hold-off.
		run_random(230, 100);
		drain();

		// Phase 2: roles swapped.
		snd_idle_pct <= 64;
		rcv_idle_pct <= 12;
		run_random(230, -1);
		drain();

		// Phase 3: full rate both ways, with another hold-off to fill the block.
		snd_idle_pct <= 0;
		rcv_idle_pct <= 0;
		run_random(240, 120);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d responses checked, %0d lookup hits, %0d refused for no free table,",
			checked, lookup_hits, pool_empty);
		$display("summary: %0d 4 KiB maps blocked by a huge page, %0d mismatches",
			huge_blocked, errors);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
